@@ rtl/xcfr_pkg.sv @@
// xcfr_pkg: shared types and constants of the xor checked frame resync core
// no dependencies; imported by the interfaces, the core and the testbench
package xcfr_pkg;

   localparam int WindowDepthDef = 128;
   localparam int PacketBytesDef = 64;

   // frame length and pending byte limits
   localparam int MinLen     = 2;
   localparam int MinPending = 4;
   localparam int KbusExtra  = 2;
   localparam int ShortKbus  = 4;

   localparam int ByteWidth  = 8;
   localparam int IndexWidth = 6;
   // holds a whole frame length, up to 64
   localparam int LenWidth   = 7;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POLL = 1'b1
   } xcfr_op_type;

   typedef enum logic {
      KIND_DS2  = 1'b0,
      KIND_KBUS = 1'b1
   } xcfr_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LEN_CHK,
      ST_SUM_RD,
      ST_SUM_CHK,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_DONE
   } xcfr_state_type;

endpackage

@@ rtl/xcfr_req_if.sv @@
// xcfr_req_if: input channel of the frame resync core, valid/ready with payload
// depends on xcfr_pkg for field widths
interface xcfr_req_if;
   import xcfr_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 opcode;
   logic [ByteWidth-1:0] rx_byte;

   modport source (output valid, opcode, rx_byte, input ready);
   modport sink   (input valid, opcode, rx_byte, output ready);
endinterface

@@ rtl/xcfr_rsp_if.sv @@
// xcfr_rsp_if: result channel of the frame resync core, one frame byte per beat
// depends on xcfr_pkg for field widths
interface xcfr_rsp_if;
   import xcfr_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [ByteWidth-1:0]  frame_byte;
   logic [IndexWidth-1:0] byte_index;
   logic                  frame_kind;
   logic                  last;

   modport source (output valid, frame_byte, byte_index, frame_kind, last, input ready);
   modport sink   (input valid, frame_byte, byte_index, frame_kind, last, output ready);
endinterface

@@ rtl/xcfr_ram.sv @@
// xcfr_ram: generic single write port, single read port ram with registered read
// no dependencies
module xcfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/xor_checked_frame_resync_core.sv @@
// xor_checked_frame_resync_core: resyncs a bus byte stream into xor checked frames
// depends on xcfr_pkg, xcfr_req_if, xcfr_rsp_if and xcfr_ram
//
// Each input beat either pushes a received byte into a circular window of pending
// bytes (dropping the oldest byte when the window is full) or only polls. The core
// then rescans the window: the byte at offset 1 is a length, a bad length drops one
// byte, a good one is checked first as a DS2 frame and then as a K-Bus frame of
// length+2 bytes, both with an xor checksum; a failed check drops one byte and the
// scan repeats, and too few pending bytes ends the scan. At most one frame comes
// out per input beat, one byte per result beat with its index, kind and last flag.
// All window reads go through one ram read port. ST_IDLE writes a push; ST_SCAN
// reads and ST_LEN_CHK checks a length probe; ST_SUM_RD reads and ST_SUM_CHK
// checks or adds each checksum byte; ST_EMIT_RD reads and ST_EMIT_LD loads each
// output byte, waiting on result stalls; ST_DONE drops the frame. Items take
// longest when the pending bytes are noise that keeps passing the length probe
// and fails both checksums at every offset. The core is not ready while it scans
// or emits. The window needs no clearing after reset; a finished frame's last
// beat may wait in the output register while the next beat is accepted.
module xor_checked_frame_resync_core #(
   parameter int WINDOW_DEPTH = xcfr_pkg::WindowDepthDef,
   parameter int PACKET_BYTES = xcfr_pkg::PacketBytesDef
) (
   input  logic       clock,
   input  logic       reset,
   xcfr_req_if.sink   req_chan,
   xcfr_rsp_if.source rsp_chan
);
   import xcfr_pkg::*;

   localparam int HW = $clog2(WINDOW_DEPTH);
   localparam int CW = $clog2(WINDOW_DEPTH + 1);
   localparam int AW = HW + 1;
   localparam int XW = (CW > ByteWidth) ? CW : ByteWidth;
   localparam logic [XW-1:0] DepthX  = XW'(WINDOW_DEPTH);
   localparam logic [XW-1:0] MaxLenX = XW'(PACKET_BYTES - 2);
   localparam logic [XW-1:0] MinLenX = XW'(MinLen);

   xcfr_state_type          state_ff, state_in;
   logic [HW-1:0]           head_ff, head_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [IndexWidth-1:0]   len_ff, len_in;
   logic [IndexWidth-1:0]   k_ff, k_in;
   logic [ByteWidth-1:0]    sum_ff, sum_in;
   xcfr_kind_type           kind_ff, kind_in;
   logic [LenWidth-1:0]     nbytes_ff, nbytes_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ByteWidth-1:0]    frame_byte_ff, frame_byte_in;
   logic [IndexWidth-1:0]   byte_index_ff, byte_index_in;
   logic                    frame_kind_ff, frame_kind_in;
   logic                    last_ff, last_in;

   logic                    ram_we;
   logic [HW-1:0]           ram_waddr;
   logic [ByteWidth-1:0]    ram_wdata;
   logic                    ram_re;
   logic [HW-1:0]           ram_raddr;
   logic [ByteWidth-1:0]    rd_byte;

   logic                    out_free;
   logic                    len_bad;
   logic                    len_short;
   logic                    kbus_short;
   logic                    at_ds2_sum;
   logic                    at_kbus_sum;
   logic                    sum_match;
   logic                    emit_last;
   logic                    extra_drop;
   logic [CW-1:0]           drop_amt;

   // window slot of an offset from the head, offset at most the depth
   function automatic logic [HW-1:0] wrap_add(input logic [HW-1:0] base,
                                              input logic [CW-1:0] off);
      logic [AW-1:0] s;
      s = AW'(base) + AW'(off);
      if (s >= AW'(WINDOW_DEPTH)) begin
         s = s - AW'(WINDOW_DEPTH);
      end
      return s[HW-1:0];
   endfunction

   xcfr_ram #(
      .WIDTH (ByteWidth),
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (rd_byte)
   );

   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign len_bad     = (XW'(rd_byte) < MinLenX) || (XW'(rd_byte) > MaxLenX);
   assign len_short   = XW'(rd_byte) > XW'(count_ff);
   assign kbus_short  = (XW'(len_ff) + XW'(KbusExtra)) > XW'(count_ff);
   assign at_ds2_sum  = k_ff == (len_ff - IndexWidth'(1));
   assign at_kbus_sum = k_ff == (len_ff + IndexWidth'(1));
   assign sum_match   = rd_byte == sum_ff;
   assign emit_last   = (LenWidth'(k_ff) + LenWidth'(1)) == nbytes_ff;
   // a 4-byte k-bus frame also takes the byte after it, if one waits
   assign extra_drop  = (kind_ff == KIND_KBUS) && (nbytes_ff == LenWidth'(ShortKbus))
                        && (XW'(count_ff) > XW'(nbytes_ff));
   assign drop_amt    = CW'(nbytes_ff) + CW'(extra_drop);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            state_in = (XW'(count_ff) >= XW'(MinPending)) ? ST_LEN_CHK : ST_IDLE;
         end
         ST_LEN_CHK: begin
            if (len_bad) begin
               state_in = ST_SCAN;
            end else if (len_short) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SUM_RD;
            end
         end
         ST_SUM_RD: begin
            state_in = ST_SUM_CHK;
         end
         ST_SUM_CHK: begin
            if (at_ds2_sum) begin
               if (sum_match) begin
                  state_in = ST_EMIT_RD;
               end else if (kbus_short) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_SUM_RD;
               end
            end else if (at_kbus_sum) begin
               state_in = sum_match ? ST_EMIT_RD : ST_SCAN;
            end else begin
               state_in = ST_SUM_RD;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (out_free) begin
               state_in = emit_last ? ST_DONE : ST_EMIT_RD;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and ram control
   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      len_in        = len_ff;
      k_in          = k_ff;
      sum_in        = sum_ff;
      kind_in       = kind_ff;
      nbytes_in     = nbytes_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      frame_byte_in = frame_byte_ff;
      byte_index_in = byte_index_ff;
      frame_kind_in = frame_kind_ff;
      last_in       = last_ff;
      ram_we        = 1'b0;
      ram_waddr     = wrap_add(head_ff, count_ff);
      ram_wdata     = req_chan.rx_byte;
      ram_re        = 1'b0;
      ram_raddr     = wrap_add(head_ff, CW'(k_ff));
      req_chan.ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid && (req_chan.opcode == OP_PUSH)) begin
               // a full window overwrites its oldest slot, which is the write slot
               ram_we = 1'b1;
               if (XW'(count_ff) == DepthX) begin
                  head_in = wrap_add(head_ff, CW'(1));
               end else begin
                  count_in = count_ff + CW'(1);
               end
            end
         end
         ST_SCAN: begin
            ram_re    = 1'b1;
            ram_raddr = wrap_add(head_ff, CW'(1));
         end
         ST_LEN_CHK: begin
            len_in = rd_byte[IndexWidth-1:0];
            sum_in = '0;
            k_in   = '0;
            if (len_bad) begin
               head_in  = wrap_add(head_ff, CW'(1));
               count_in = count_ff - CW'(1);
            end
         end
         ST_SUM_RD: begin
            ram_re = 1'b1;
         end
         ST_SUM_CHK: begin
            if (at_ds2_sum && sum_match) begin
               kind_in   = KIND_DS2;
               nbytes_in = LenWidth'(len_ff);
               k_in      = '0;
            end else if (at_kbus_sum) begin
               if (sum_match) begin
                  kind_in   = KIND_KBUS;
                  nbytes_in = LenWidth'(len_ff) + LenWidth'(KbusExtra);
                  k_in      = '0;
               end else begin
                  head_in  = wrap_add(head_ff, CW'(1));
                  count_in = count_ff - CW'(1);
               end
            end else begin
               sum_in = sum_ff ^ rd_byte;
               k_in   = k_ff + IndexWidth'(1);
            end
         end
         ST_EMIT_RD: begin
            ram_re = 1'b1;
         end
         ST_EMIT_LD: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               frame_byte_in = rd_byte;
               byte_index_in = k_ff;
               frame_kind_in = kind_ff;
               last_in       = emit_last;
               k_in          = k_ff + IndexWidth'(1);
            end
         end
         ST_DONE: begin
            head_in  = wrap_add(head_ff, drop_amt);
            count_in = count_ff - drop_amt;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff        <= len_in;
      k_ff          <= k_in;
      sum_ff        <= sum_in;
      kind_ff       <= kind_in;
      nbytes_ff     <= nbytes_in;
      frame_byte_ff <= frame_byte_in;
      byte_index_ff <= byte_index_in;
      frame_kind_ff <= frame_kind_in;
      last_ff       <= last_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.frame_byte = frame_byte_ff;
   assign rsp_chan.byte_index = byte_index_ff;
   assign rsp_chan.frame_kind = frame_kind_ff;
   assign rsp_chan.last       = last_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      XW'(count_ff) <= DepthX)
      else $error("window count above depth");

   a_len_probe_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEN_CHK) |-> (XW'(count_ff) >= XW'(MinPending)))
      else $error("length probed with too few pending bytes");

   a_last_closes_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_LD && out_free && emit_last) |=> (state_ff == ST_DONE))
      else $error("final frame beat did not close the frame");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_chan.ready)
      else $error("input taken while scanning");
`endif

endmodule

@@ tb/sv/xcfr_frame_checker.sv @@
// xcfr_frame_checker: watches the request and result channels of the frame resync
// core, predicts every frame beat from its own copy of the byte window and compares
// depends on xcfr_pkg, xcfr_req_if and xcfr_rsp_if
module xcfr_frame_checker #(
   parameter int WINDOW_DEPTH = xcfr_pkg::WindowDepthDef,
   parameter int PACKET_BYTES = xcfr_pkg::PacketBytesDef
) (
   input  logic clock,
   input  logic reset,
   xcfr_req_if  req,
   xcfr_rsp_if  rsp,
   output int   fail_count,
   output int   pending_beats,
   output int   ds2_frames,
   output int   kbus_frames
);
   timeunit 1ns;
   timeprecision 1ps;
   import xcfr_pkg::*;

   typedef struct packed {
      logic [ByteWidth-1:0]  frame_byte;
      logic [IndexWidth-1:0] byte_index;
      xcfr_kind_type         frame_kind;
      logic                  last;
   } frame_beat_type;

   logic [ByteWidth-1:0] window_mem [WINDOW_DEPTH];
   int unsigned          win_head;
   int unsigned          win_count;
   frame_beat_type       frame_beats_due [$];

   function automatic int unsigned win_byte(input int unsigned off);
      return window_mem[(win_head + off) % WINDOW_DEPTH];
   endfunction

   function automatic void drop_bytes(input int unsigned n);
      if (n > win_count) begin
         n = win_count;
      end
      win_head  = (win_head + n) % WINDOW_DEPTH;
      win_count = win_count - n;
   endfunction

   function automatic void queue_frame(input int unsigned len, input xcfr_kind_type kind);
      for (int unsigned k = 0; k < len; k++) begin
         frame_beats_due.push_back(frame_beat_type'{8'(win_byte(k)), 6'(k), kind,
                                                    k + 1 == len});
      end
      if (kind == KIND_DS2) begin
         ds2_frames++;
      end else begin
         kbus_frames++;
      end
   endfunction

   // one request beat: optional push, then rescan until a frame, a wait or too few bytes
   function automatic void scan_window(input xcfr_op_type op, input logic [ByteWidth-1:0] data);
      int unsigned len;
      int unsigned sum;
      bit          busy;
      if (op == OP_PUSH) begin
         if (win_count >= WINDOW_DEPTH) begin
            drop_bytes(1);
         end
         window_mem[(win_head + win_count) % WINDOW_DEPTH] = data;
         win_count++;
      end
      busy = 1'b1;
      while (busy && win_count >= MinPending) begin
         len = win_byte(1);
         if (len < MinLen || len > PACKET_BYTES - 2) begin
            drop_bytes(1);
         end else if (len > win_count) begin
            busy = 1'b0;
         end else begin
            sum = 0;
            for (int unsigned k = 0; k + 1 < len; k++) begin
               sum ^= win_byte(k);
            end
            if (win_byte(len - 1) == sum) begin
               queue_frame(len, KIND_DS2);
               drop_bytes(len);
               busy = 1'b0;
            end else if (len + KbusExtra > win_count) begin
               busy = 1'b0;
            end else begin
               sum ^= win_byte(len - 1) ^ win_byte(len);
               if (win_byte(len + 1) == sum) begin
                  queue_frame(len + KbusExtra, KIND_KBUS);
                  drop_bytes(len + KbusExtra);
                  // a short k-bus frame also eats the byte after it
                  if (len + KbusExtra == ShortKbus) begin
                     drop_bytes(1);
                  end
                  busy = 1'b0;
               end else begin
                  drop_bytes(1);
               end
            end
         end
      end
   endfunction

   function automatic void note_fail(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%t %s", $realtime, msg);
      end
   endfunction

   always @(posedge clock) begin
      frame_beat_type got;
      frame_beat_type want;
      if (reset) begin
         win_head    = 0;
         win_count   = 0;
         fail_count  = 0;
         ds2_frames  = 0;
         kbus_frames = 0;
         frame_beats_due.delete();
      end else begin
         // results first: a last beat may still be leaving as the next request lands
         if (rsp.valid && rsp.ready) begin
            got = frame_beat_type'{rsp.frame_byte, rsp.byte_index,
                                   xcfr_kind_type'(rsp.frame_kind), rsp.last};
            if (frame_beats_due.size() == 0) begin
               note_fail($sformatf("unexpected frame beat: byte %02h index %0d kind %0d last %0d",
                                   got.frame_byte, got.byte_index, got.frame_kind, got.last));
            end else begin
               want = frame_beats_due.pop_front();
               if (got !== want) begin
                  note_fail($sformatf({"frame beat mismatch: expected byte %02h index %0d",
                                       " kind %0d last %0d, got byte %02h index %0d",
                                       " kind %0d last %0d"},
                                      want.frame_byte, want.byte_index, want.frame_kind,
                                      want.last, got.frame_byte, got.byte_index,
                                      got.frame_kind, got.last));
               end
            end
         end
         if (req.valid && req.ready) begin
            scan_window(xcfr_op_type'(req.opcode), req.rx_byte);
         end
      end
      pending_beats <= frame_beats_due.size();
   end

endmodule

@@ tb/sv/tb.sv @@
// tb: stimulus and verdict for the xor checked frame resync core
// depends on xcfr_pkg, both channel interfaces, the core and xcfr_frame_checker
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import xcfr_pkg::*;

   localparam int RandItems     = 420;
   localparam int WatchdogLimit = 50000;
   localparam int TailCycles    = 2000;

   logic clock;
   logic reset;

   int fail_count;
   int pending_beats;
   int ds2_frames;
   int kbus_frames;

   int idle_pct;
   int stall_pct;
   int items_sent;
   int quiet_cycles;

   logic [ByteWidth-1:0] bad_len_bytes [$] = '{8'h00, 8'hFF, 8'h01, 8'h3F, 8'h00, 8'h00, 8'h00};

   xcfr_req_if req_chan ();
   xcfr_rsp_if rsp_chan ();

   xor_checked_frame_resync_core #(
      .WINDOW_DEPTH(WindowDepthDef),
      .PACKET_BYTES(PacketBytesDef)
   ) DUT (
      .clock,
      .reset,
      .req_chan,
      .rsp_chan
   );

   xcfr_frame_checker #(
      .WINDOW_DEPTH(WindowDepthDef),
      .PACKET_BYTES(PacketBytesDef)
   ) frame_check (
      .clock,
      .reset,
      .req(req_chan),
      .rsp(rsp_chan),
      .fail_count,
      .pending_beats,
      .ds2_frames,
      .kbus_frames
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("watchdog: no beat moved for %0d cycles", WatchdogLimit);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic send_item(input xcfr_op_type op, input logic [ByteWidth-1:0] data);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      req_chan.valid   <= 1'b1;
      req_chan.opcode  <= op;
      req_chan.rx_byte <= data;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   task automatic hold_until_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_beats != 0) @(posedge clock);
   endtask

   // first < 0 picks a random leading byte
   task automatic send_frame(input xcfr_kind_type kind, input int unsigned len,
                             input bit corrupt, input int first);
      logic [ByteWidth-1:0] fb [$];
      logic [ByteWidth-1:0] sum;
      int unsigned          size;
      size = (kind == KIND_KBUS) ? len + KbusExtra : len;
      if (size == MinLen) begin
         // in a two byte frame the length byte is its own checksum
         fb.push_back(8'(len));
         fb.push_back(8'(len));
      end else begin
         fb.push_back((first < 0) ? 8'($urandom_range(0, 255)) : 8'(first));
         fb.push_back(8'(len));
         while (fb.size() < size - 1) fb.push_back(8'($urandom_range(0, 255)));
         sum = '0;
         foreach (fb[i]) sum ^= fb[i];
         fb.push_back(sum);
      end
      if (corrupt) begin
         fb[size-1] ^= 8'($urandom_range(1, 255));
      end
      foreach (fb[i]) begin
         if ($urandom_range(0, 9) == 0) begin
            send_item(OP_POLL, 8'($urandom_range(0, 255)));
         end
         send_item(OP_PUSH, fb[i]);
      end
   endtask

   // a maximal length header holds the scan while frames pile up behind it
   task automatic send_backlog();
      int unsigned   piled;
      int unsigned   len;
      xcfr_kind_type kind;
      send_item(OP_PUSH, 8'($urandom_range(0, 255)));
      send_item(OP_PUSH, 8'(PacketBytesDef - 2));
      send_frame(KIND_KBUS, MinLen, 1'b0, 0);
      send_item(OP_PUSH, 8'($urandom_range(0, 255)));
      piled = ShortKbus + 1;
      while (piled < PacketBytesDef) begin
         kind = xcfr_kind_type'($urandom_range(0, 1));
         len  = $urandom_range(MinLen, 8);
         send_frame(kind, len, 1'b0, -1);
         piled += (kind == KIND_KBUS) ? len + KbusExtra : len;
      end
      repeat (8) send_item(OP_POLL, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      int unsigned   directed_items;
      int unsigned   rand_items;
      int unsigned   phase;
      int unsigned   new_phase;
      int unsigned   pick;
      int unsigned   len;
      xcfr_kind_type kind;

      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.opcode  <= OP_PUSH;
      req_chan.rx_byte <= '0;
      idle_pct   = 0;
      stall_pct  = 0;
      items_sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty poll, shortest frames of both kinds, bad lengths, broken checksum
      send_item(OP_POLL, 8'h00);
      send_frame(KIND_DS2, MinLen, 1'b0, 0);
      send_frame(KIND_KBUS, MinLen, 1'b0, 8'h11);
      foreach (bad_len_bytes[i]) send_item(OP_PUSH, bad_len_bytes[i]);
      send_frame(KIND_DS2, 5, 1'b0, 0);
      send_frame(KIND_DS2, 5, 1'b1, 0);
      // scan waits on a frame that is still short
      send_item(OP_POLL, 8'hFF);
      send_item(OP_PUSH, 8'h80);
      send_item(OP_PUSH, 8'h7F);
      hold_until_drained();
      directed_items = items_sent;

      send_backlog();
      phase      = 0;
      rand_items = items_sent - directed_items;
      while (rand_items < RandItems) begin
         new_phase = rand_items * 4 / RandItems;
         if (new_phase != phase) begin
            phase = new_phase;
            hold_until_drained();
            case (phase)
               1: begin
                  idle_pct  = 54;
                  stall_pct = 0;
               end
               2: begin
                  idle_pct  = 0;
                  stall_pct = 54;
               end
               default: begin
                  idle_pct  = 36;
                  stall_pct = 36;
               end
            endcase
         end
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            kind = xcfr_kind_type'($urandom_range(0, 1));
            if ($urandom_range(0, 24) == 0) begin
               len = $urandom_range(0, 1) ? PacketBytesDef - 2 : $urandom_range(11, 61);
            end else begin
               len = $urandom_range(MinLen, 10);
            end
            send_frame(kind, len, $urandom_range(0, 6) == 0, -1);
         end else if (pick < 59) begin
            send_backlog();
         end else if (pick < 74) begin
            repeat ($urandom_range(1, 6)) send_item(OP_PUSH, 8'($urandom_range(0, 255)));
         end else if (pick < 84) begin
            repeat ($urandom_range(1, 3)) send_item(OP_POLL, 8'($urandom_range(0, 255)));
         end else if (pick < 96) begin
            // bytes that read as plausible lengths
            repeat ($urandom_range(1, 4)) begin
               send_item(OP_PUSH, 8'($urandom_range(MinLen, PacketBytesDef - 2)));
            end
         end else begin
            hold_until_drained();
         end
         rand_items = items_sent - directed_items;
      end

      hold_until_drained();
      repeat (TailCycles) @(posedge clock);
      $display("run covered %0d request beats, %0d DS2 and %0d K-Bus frames predicted,",
               items_sent, ds2_frames, kbus_frames);
      $display("under no idling, sender idling, receiver stalls and both together");
      if (fail_count == 0 && pending_beats == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d failures, %0d frame beats still due", fail_count, pending_beats);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
